FILE: rtl/sxl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxl_pkg: shared types, constants and table builders
// Word formats, matrix coefficients, pipeline depths and the elaboration-time
// node functions for the sRGB power curve and the cube-root curve.
// ----------------------------------------------------------------------------
package sxl_pkg;

  // default number of curve table segments
  localparam int CURVE_SEGMENTS_DEF = 256;

  // stage counts of each part of the pipeline
  localparam int LIN_LAT  = 4;
  localparam int MAT_LAT  = 5;
  localparam int PIV_LAT  = 22;
  localparam int LAB_LAT  = 2;
  localparam int PIPE_LAT = LIN_LAT + MAT_LAT + PIV_LAT + LAB_LAT;

  // register indexes
  localparam logic [1:0] CFG_WHITE_X = 2'd0;
  localparam logic [1:0] CFG_WHITE_Y = 2'd1;
  localparam logic [1:0] CFG_WHITE_Z = 2'd2;

  // reset white point (D65, Q1.16)
  localparam logic [16:0] WHITE_X_RST = 17'd62290;
  localparam logic [16:0] WHITE_Y_RST = 17'd65536;
  localparam logic [16:0] WHITE_Z_RST = 17'd71358;

  localparam logic [16:0] SAT17 = 17'h1FFFF;

  // sRGB to XYZ matrix, units of 1e-7, [row][column]
  localparam logic [23:0] MAT_COEF [3][3] = '{
    '{24'd4124564, 24'd3575761, 24'd1804375},
    '{24'd2126729, 24'd7151522, 24'd721750},
    '{24'd193339,  24'd1191920, 24'd9503041}
  };

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [16:0]        cie_x;
    logic [16:0]        cie_y;
    logic [16:0]        cie_z;
    logic [14:0]        lightness;
    logic signed [15:0] green_red_axis;
    logic signed [15:0] blue_yellow_axis;
  } color_t;

  typedef struct packed {
    logic [16:0] x;
    logic [16:0] y;
    logic [16:0] z;
  } xyz_t;

  // r^5 in Q24
  function automatic longint unsigned fifth_power_q24(input longint unsigned r);
    longint unsigned a;
    a = (r * r) >> 24;
    a = (a * r) >> 24;
    a = (a * r) >> 24;
    a = (a * r) >> 24;
    return a;
  endfunction

  // power-curve node k of s segments, Q16
  function automatic logic [16:0] pow_node(input int s, input int k);
    longint unsigned sl, kl, num, den, w, w2, r, t, v;
    int b;
    sl = longint'(s);
    kl = longint'(k);
    num = 64'd1000 * kl * 64'd65536 + 64'd55 * 64'd65535 * sl;
    den = 64'd1055 * 64'd65535 * sl;
    // floor quotient by bit search
    w = 64'd0;
    for (b = 24; b >= 0; b--) begin
      t = w | (64'd1 << b);
      if (t * den <= (num << 24)) w = t;
    end
    w2 = (w * w) >> 24;
    // floor fifth root of w^2
    r = 64'd0;
    for (b = 24; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (fifth_power_q24(t) <= w2) r = t;
    end
    v = (w2 * r + (64'd1 << 31)) >> 32;
    return v[16:0];
  endfunction

  // cube-root node k over [0, 2) of s segments, Q16
  function automatic logic [16:0] cbrt_node(input int s, input int k);
    longint unsigned sl, kl, y, t;
    int b;
    sl = longint'(s);
    kl = longint'(k);
    y = 64'd0;
    for (b = 16; b >= 0; b--) begin
      t = y | (64'd1 << b);
      if (t * t * t * sl <= (kl << 49)) y = t;
    end
    return y[16:0];
  endfunction

endpackage

FILE: rtl/sxl_curve_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxl_curve_lane: sRGB linearization for one channel
// Linear segment through a reciprocal multiply, power segment through an
// interpolated constant table. Four register stages.
// ----------------------------------------------------------------------------
module sxl_curve_lane #(
  parameter int SEGMENTS = sxl_pkg::CURVE_SEGMENTS_DEF
) (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] code,
  output logic [16:0] lin
);
  import sxl_pkg::*;

  localparam int AW = $clog2(SEGMENTS + 1);
  localparam int PW = 16 + AW;
  localparam logic [31:0] LIN_DIV   = 32'd8467122;
  localparam logic [24:0] LIN_RECIP = 25'(64'd281474976710656 / 64'd8467122);

  typedef logic [16:0] rom_t [SEGMENTS + 1];

  function automatic rom_t build_rom();
    rom_t tab;
    for (int k = 0; k <= SEGMENTS; k++) tab[k] = pow_node(SEGMENTS, k);
    return tab;
  endfunction

  localparam rom_t POW_ROM = build_rom();

  // stage 1: segment select, table address, linear numerator
  logic [PW-1:0] pos;
  logic [31:0]   n_c;
  assign pos = PW'(code) * PW'(SEGMENTS);
  assign n_c = 32'(code[11:0]) * 32'd655360 + 32'd4233561;

  logic          seg1;
  logic [31:0]   n1;
  logic [AW-1:0] k1, k1n;
  logic [15:0]   fr1;

  always_ff @(posedge clk) begin
    if (en) begin
      seg1 <= (code < 16'd2651);
      n1   <= n_c;
      k1   <= pos[PW-1:16];
      k1n  <= pos[PW-1:16] + 1'b1;
      fr1  <= pos[15:0];
    end
  end

  // stage 2: table read, reciprocal product
  logic [16:0] lo2, hi2;
  logic [56:0] prod2;
  logic [31:0] n2;
  logic [15:0] fr2;
  logic        seg2;

  always_ff @(posedge clk) begin
    if (en) begin
      lo2   <= POW_ROM[k1];
      hi2   <= POW_ROM[k1n];
      prod2 <= 57'(n1) * 57'(LIN_RECIP);
      n2    <= n1;
      fr2   <= fr1;
      seg2  <= seg1;
    end
  end

  // stage 3: quotient estimate, interpolation product
  logic [8:0]  q0;
  logic [16:0] diff;
  assign q0   = prod2[56:48];
  assign diff = (hi2 < lo2) ? 17'd0 : hi2 - lo2;

  logic [8:0]  q3;
  logic [31:0] qd3, n3;
  logic [32:0] dp3;
  logic [16:0] lo3;
  logic        seg3;

  always_ff @(posedge clk) begin
    if (en) begin
      q3   <= q0;
      qd3  <= 32'(q0) * LIN_DIV;
      n3   <= n2;
      dp3  <= 33'(diff) * 33'(fr2);
      lo3  <= lo2;
      seg3 <= seg2;
    end
  end

  // stage 4: quotient correction or rounded interpolation
  logic [9:0]  corr;
  logic [32:0] dp_rnd;
  logic [16:0] interp;
  assign corr   = ((n3 - qd3) >= LIN_DIV) ? 10'(q3) + 10'd1 : 10'(q3);
  assign dp_rnd = (dp3 + 33'd32768) >> 16;
  assign interp = lo3 + dp_rnd[16:0];

  always_ff @(posedge clk) begin
    if (en) lin <= seg3 ? 17'(corr) : interp;
  end

endmodule

FILE: rtl/sxl_pivot_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxl_pivot_lane: white-point ratio and CIELAB pivot for one component
// Pipelined restoring divider (one quotient bit a stage), then the linear
// pivot segment or the range-scaled, interpolated cube-root table.
// ----------------------------------------------------------------------------
module sxl_pivot_lane #(
  parameter int SEGMENTS = sxl_pkg::CURVE_SEGMENTS_DEF
) (
  input  logic        clk,
  input  logic        en,
  input  logic [16:0] value,
  input  logic [16:0] white,
  output logic [16:0] fval
);
  import sxl_pkg::*;

  localparam int AW = $clog2(SEGMENTS + 1);
  localparam int PW = 17 + AW;
  localparam int DIV_STEPS = 16;
  localparam logic [15:0] SM_RECIP = 16'(64'd134217728 / 64'd3625);
  localparam logic [26:0] SM_DIV   = 27'd3625;

  typedef logic [16:0] rom_t [SEGMENTS + 1];

  function automatic rom_t build_rom();
    rom_t tab;
    for (int k = 0; k <= SEGMENTS; k++) tab[k] = cbrt_node(SEGMENTS, k);
    return tab;
  endfunction

  localparam rom_t CBRT_ROM = build_rom();

  // divider entry: rounded dividend, overflow check
  logic [33:0] dvd;
  assign dvd = {1'b0, value, 16'd0} + 34'(white[16:1]);

  logic [33:0] rem [DIV_STEPS + 1];
  logic [16:0] quo [DIV_STEPS + 1];
  logic [16:0] dsr [DIV_STEPS + 1];
  logic        sat [DIV_STEPS + 1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= dvd;
      quo[0] <= 17'd0;
      dsr[0] <= white;
      sat[0] <= (white == 17'd0) || (dvd >= {white, 17'd0});
    end
  end

  // one quotient bit per stage, MSB first
  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    localparam int SH = DIV_STEPS + 1 - j;
    logic [33:0] trial;
    assign trial = 34'(dsr[j-1]) << SH;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[j-1] >= trial) begin
          rem[j] <= rem[j-1] - trial;
          quo[j] <= quo[j-1] | (17'd1 << SH);
        end else begin
          rem[j] <= rem[j-1];
          quo[j] <= quo[j-1];
        end
        dsr[j] <= dsr[j-1];
        sat[j] <= sat[j-1];
      end
    end
  end

  // last quotient bit
  logic [16:0] quo_f;
  logic        sat_f;
  always_ff @(posedge clk) begin
    if (en) begin
      quo_f <= (rem[DIV_STEPS] >= 34'(dsr[DIV_STEPS])) ? (quo[DIV_STEPS] | 17'd1)
                                                      : quo[DIV_STEPS];
      sat_f <= sat[DIV_STEPS];
    end
  end

  // pivot stage 1: segment select, range scaling, table address
  logic [16:0]   v;
  logic [30:0]   nsm;
  logic [16:0]   m;
  logic [1:0]    e;
  logic [PW-1:0] pos;

  assign v   = sat_f ? SAT17 : quo_f;
  assign nsm = 31'(v[9:0]) * 31'd903292 + 31'd1048634000;
  assign pos = PW'(m) * PW'(SEGMENTS);

  always_comb begin
    m = v;
    e = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (m < 17'd16384) begin
        m = m << 3;
        e = e + 2'd1;
      end
    end
  end

  logic          small1;
  logic [30:0]   nsm1;
  logic [AW-1:0] k1, k1n;
  logic [16:0]   fr1;
  logic [1:0]    e1;

  always_ff @(posedge clk) begin
    if (en) begin
      small1 <= (v < 17'd581);
      nsm1   <= nsm;
      k1     <= pos[PW-1:17];
      k1n    <= pos[PW-1:17] + 1'b1;
      fr1    <= pos[16:0];
      e1     <= e;
    end
  end

  // pivot stage 2: table read, reciprocal product
  logic [16:0] lo2, hi2;
  logic [41:0] prod2;
  logic [25:0] n2;
  logic [16:0] fr2;
  logic [1:0]  e2;
  logic        small2;

  always_ff @(posedge clk) begin
    if (en) begin
      lo2    <= CBRT_ROM[k1];
      hi2    <= CBRT_ROM[k1n];
      prod2  <= 42'(nsm1[30:5]) * 42'(SM_RECIP);
      n2     <= nsm1[30:5];
      fr2    <= fr1;
      e2     <= e1;
      small2 <= small1;
    end
  end

  // pivot stage 3: quotient estimate, interpolation product
  logic [14:0] q0;
  logic [16:0] diff;
  assign q0   = prod2[41:27];
  assign diff = (hi2 < lo2) ? 17'd0 : hi2 - lo2;

  logic [14:0] q3;
  logic [26:0] qd3, n3;
  logic [33:0] dp3;
  logic [16:0] lo3;
  logic [1:0]  e3;
  logic        small3;

  always_ff @(posedge clk) begin
    if (en) begin
      q3     <= q0;
      qd3    <= 27'(q0) * SM_DIV;
      n3     <= 27'(n2);
      dp3    <= 34'(diff) * 34'(fr2);
      lo3    <= lo2;
      e3     <= e2;
      small3 <= small2;
    end
  end

  // pivot stage 4: correction, or interpolate and undo the range scaling
  logic [15:0] corr;
  logic [33:0] dp_rnd;
  logic [17:0] f, rnd, fv;

  assign corr   = ((n3 - qd3) >= SM_DIV) ? 16'(q3) + 16'd1 : 16'(q3);
  assign dp_rnd = (dp3 + 34'd65536) >> 17;
  assign f      = 18'(lo3) + 18'(dp_rnd[16:0]);
  assign rnd    = (18'd1 << e3) >> 1;
  assign fv     = (f + rnd) >> e3;

  always_ff @(posedge clk) begin
    if (en) fval <= small3 ? 17'(corr) : fv[16:0];
  end

endmodule

FILE: rtl/srgb_to_xyz_and_cielab.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srgb_to_xyz_and_cielab: sRGB pixel to CIE XYZ and CIELAB
// Pipeline stages: 4 linearization, 5 matrix, 22 ratio/pivot (17-step
// pipelined divider), 2 Lab. Throughput one word per cycle unless stalled;
// the whole pipeline holds while a finished word waits at the output.
// Reset (synchronous) empties the pipeline and loads the D65 white point;
// curve tables are constants and need no fill.
// ----------------------------------------------------------------------------
module srgb_to_xyz_and_cielab #(
  parameter int CURVE_TABLE_SEGMENTS = sxl_pkg::CURVE_SEGMENTS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            pix_valid,
  output logic            pix_ready,
  input  sxl_pkg::pixel_t pix_word,
  output logic            res_valid,
  input  logic            res_ready,
  output sxl_pkg::color_t res_word,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [16:0]     cfg_data
);
  import sxl_pkg::*;

  localparam int XYZ_DLY    = PIV_LAT + LAB_LAT;
  localparam logic [17:0] MAT_RECIP = 18'(64'd17179869184 / 64'd78125);
  localparam logic [33:0] MAT_DIV   = 34'd78125;

  // pipeline advance and valid chain
  logic                en;
  logic [PIPE_LAT-1:0] vld;

  assign en        = !vld[PIPE_LAT-1] || res_ready;
  assign pix_ready = en;
  assign res_valid = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], pix_valid};
    end
  end

  // white point registers
  logic [16:0] white [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      white[0] <= WHITE_X_RST;
      white[1] <= WHITE_Y_RST;
      white[2] <= WHITE_Z_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WHITE_X: white[0] <= cfg_data;
        CFG_WHITE_Y: white[1] <= cfg_data;
        CFG_WHITE_Z: white[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // linearization lanes
  logic [15:0] chan [3];
  logic [16:0] lin  [3];

  assign chan[0] = pix_word.red;
  assign chan[1] = pix_word.green;
  assign chan[2] = pix_word.blue;

  for (genvar c = 0; c < 3; c++) begin : g_curve
    sxl_curve_lane #(.SEGMENTS(CURVE_TABLE_SEGMENTS)) u_curve (
      .clk  (clk),
      .en   (en),
      .code (chan[c]),
      .lin  (lin[c])
    );
  end

  // matrix: products, rounded sums, divide by 1e7
  logic [40:0] p1  [3][3];
  logic [39:0] s2  [3];
  logic [50:0] pr3 [3];
  logic [32:0] n3  [3];
  logic [16:0] q4  [3];
  logic [33:0] qd4 [3];
  logic [32:0] n4  [3];
  logic [16:0] xyz5 [3];

  for (genvar i = 0; i < 3; i++) begin : g_mat
    logic [16:0] q0;
    logic [17:0] corr;
    assign q0   = pr3[i][50:34];
    assign corr = ((34'(n4[i]) - qd4[i]) >= MAT_DIV) ? 18'(q4[i]) + 18'd1 : 18'(q4[i]);

    for (genvar j = 0; j < 3; j++) begin : g_prod
      always_ff @(posedge clk) begin
        if (en) p1[i][j] <= 41'(MAT_COEF[i][j]) * 41'(lin[j]);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s2[i]   <= 40'(p1[i][0]) + 40'(p1[i][1]) + 40'(p1[i][2]) + 40'd5000000;
        pr3[i]  <= 51'(s2[i][39:7]) * 51'(MAT_RECIP);
        n3[i]   <= s2[i][39:7];
        q4[i]   <= q0;
        qd4[i]  <= 34'(q0) * MAT_DIV;
        n4[i]   <= n3[i];
        xyz5[i] <= (corr > 18'(SAT17)) ? SAT17 : corr[16:0];
      end
    end
  end

  // ratio and pivot lanes
  logic [16:0] fv [3];

  for (genvar i = 0; i < 3; i++) begin : g_pivot
    sxl_pivot_lane #(.SEGMENTS(CURVE_TABLE_SEGMENTS)) u_pivot (
      .clk   (clk),
      .en    (en),
      .value (xyz5[i]),
      .white (white[i]),
      .fval  (fv[i])
    );
  end

  // XYZ delay line to line up with Lab
  xyz_t xyz_dly [XYZ_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      xyz_dly[0] <= '{x: xyz5[0], y: xyz5[1], z: xyz5[2]};
      for (int i = 1; i < XYZ_DLY; i++) xyz_dly[i] <= xyz_dly[i-1];
    end
  end

  // Lab stage 1: scaled terms with rounding bias
  logic signed [17:0] dxy, dyz;
  logic signed [25:0] tl;
  logic signed [27:0] ta, tb;

  assign dxy = $signed({1'b0, fv[0]}) - $signed({1'b0, fv[1]});
  assign dyz = $signed({1'b0, fv[1]}) - $signed({1'b0, fv[2]});

  always_ff @(posedge clk) begin
    if (en) begin
      tl <= 26'sd116 * $signed({9'd0, fv[1]}) - 26'sd1048576 + 26'sd128;
      ta <= 28'sd500 * 28'(dxy) + 28'sd128;
      tb <= 28'sd200 * 28'(dyz) + 28'sd128;
    end
  end

  // Lab stage 2: floor shift and clamp into the output word
  logic signed [17:0] sl;
  logic signed [19:0] sa, sb;
  logic [14:0]        l_out;
  logic [15:0]        a_out, b_out;
  logic [14:0]        l_q;
  logic [15:0]        a_q, b_q;

  assign sl = 18'(tl >>> 8);
  assign sa = 20'(ta >>> 8);
  assign sb = 20'(tb >>> 8);

  always_comb begin
    if (sl < 18'sd0)          l_out = 15'd0;
    else if (sl > 18'sd25600) l_out = 15'd25600;
    else                      l_out = sl[14:0];
    if (sa > 20'sd32767)       a_out = 16'h7FFF;
    else if (sa < -20'sd32768) a_out = 16'h8000;
    else                       a_out = sa[15:0];
    if (sb > 20'sd32767)       b_out = 16'h7FFF;
    else if (sb < -20'sd32768) b_out = 16'h8000;
    else                       b_out = sb[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_q <= l_out;
      a_q <= a_out;
      b_q <= b_out;
    end
  end

  assign res_word = '{
    cie_x:            xyz_dly[XYZ_DLY-1].x,
    cie_y:            xyz_dly[XYZ_DLY-1].y,
    cie_z:            xyz_dly[XYZ_DLY-1].z,
    lightness:        l_q,
    green_red_axis:   $signed(a_q),
    blue_yellow_axis: $signed(b_q)
  };

  // lightness stays within 0..100
  a_light_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_word.lightness <= 15'd25600))
    else $error("lightness above range");

  // a stalled pipeline keeps its occupancy
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !pix_ready |=> $stable(vld))
    else $error("valid chain moved during stall");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !res_valid)
    else $error("word valid right after reset");

endmodule
